// ===== rtl/wbst_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and types for the window box select test block.
// No dependencies; imported by wbst_geom and window_box_select_test_unit.
package wbst_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int ID_BITS        = 32;
    localparam int EXT_BITS       = 23;
    localparam int CMD_BITS       = 3;
    localparam int IN_USER_BITS   = CMD_BITS + 1;
    localparam int PROD_BITS      = 2 * EXT_BITS;
    localparam int OUT_FIELD_BITS = ID_BITS + 1;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CMD_BITS-1:0] CMD_LINE   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_RECT   = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_CIRCLE = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CUBE   = 3'd3;

    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_A_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_A_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_B_X = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_CORNER_B_Y = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_CONTAIN    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_WIN_ID     = 3'd5;

    typedef struct packed {
        logic                sel_simple;
        logic                circ_cross;
        logic [EXT_BITS-1:0] dx;
        logic [EXT_BITS-1:0] dy;
    } t_geom;

endpackage

// ===== rtl/wbst_geom.sv =====
`timescale 1ns / 1ps
// Shape against window comparisons for one item; circle distance left for squaring.
// Depends on wbst_pkg.
module wbst_geom #(
    parameter int COORD_BITS = wbst_pkg::COORD_BITS_DEF
) (
    input  logic [wbst_pkg::CMD_BITS-1:0] i_cmd,
    input  logic [wbst_pkg::ID_BITS-1:0]  i_id,
    input  logic                          i_gizmo,
    input  logic signed [COORD_BITS-1:0]  i_x0,
    input  logic signed [COORD_BITS-1:0]  i_y0,
    input  logic signed [COORD_BITS-1:0]  i_x1,
    input  logic signed [COORD_BITS-1:0]  i_y1,
    input  logic [wbst_pkg::EXT_BITS-1:0] i_ext,
    input  logic signed [COORD_BITS-1:0]  i_lx,
    input  logic signed [COORD_BITS-1:0]  i_hx,
    input  logic signed [COORD_BITS-1:0]  i_ly,
    input  logic signed [COORD_BITS-1:0]  i_hy,
    input  logic                          i_contain,
    input  logic [wbst_pkg::ID_BITS-1:0]  i_win_id,
    output wbst_pkg::t_geom               o_geom
);
    import wbst_pkg::*;

    localparam int CW = ((COORD_BITS > EXT_BITS) ? COORD_BITS : EXT_BITS) + 3;

    logic signed [CW-1:0] x0e, y0e, lxe, hxe, lye, hye, e;
    logic signed [CW-1:0] dxl, dxh, dyl, dyh, dx, dy;
    logic signed [CW-1:0] cx2, cy2, lx2, hx2, ly2, hy2;
    logic [3:0]           c0, c1;
    logic signed [COORD_BITS-1:0] rx0, rx1, ry0, ry1;
    logic kill, line_sel, rect_sel, circ_in, cube_sel, near;

    assign x0e = CW'(i_x0);
    assign y0e = CW'(i_y0);
    assign lxe = CW'(i_lx);
    assign hxe = CW'(i_hx);
    assign lye = CW'(i_ly);
    assign hye = CW'(i_hy);
    assign e   = $signed({{(CW - EXT_BITS){1'b0}}, i_ext});

    assign kill = (i_id == i_win_id) || i_gizmo;

    // line: outcodes of both endpoints
    assign c0 = {i_y0 > i_hy, i_y0 < i_ly, i_x0 > i_hx, i_x0 < i_lx};
    assign c1 = {i_y1 > i_hy, i_y1 < i_ly, i_x1 > i_hx, i_x1 < i_lx};
    assign line_sel = i_contain ? (c0 == 4'd0 && c1 == 4'd0)
                                : (c0 == 4'd0 || c1 == 4'd0 || (c0 & c1) == 4'd0);

    // rectangle: sort corners, then box test
    assign rx0 = (i_x0 < i_x1) ? i_x0 : i_x1;
    assign rx1 = (i_x0 < i_x1) ? i_x1 : i_x0;
    assign ry0 = (i_y0 < i_y1) ? i_y0 : i_y1;
    assign ry1 = (i_y0 < i_y1) ? i_y1 : i_y0;
    assign rect_sel = i_contain
        ? (rx0 >= i_lx && rx1 <= i_hx && ry0 >= i_ly && ry1 <= i_hy)
        : !(rx1 < i_lx || rx0 > i_hx || ry1 < i_ly || ry0 > i_hy);

    // circle
    assign circ_in = (x0e - e >= lxe) && (x0e + e <= hxe)
                  && (y0e - e >= lye) && (y0e + e <= hye);
    assign dxl = lxe - x0e;
    assign dxh = x0e - hxe;
    assign dyl = lye - y0e;
    assign dyh = y0e - hye;
    assign dx  = (i_x0 < i_lx) ? dxl : ((i_x0 > i_hx) ? dxh : '0);
    assign dy  = (i_y0 < i_ly) ? dyl : ((i_y0 > i_hy) ? dyh : '0);
    assign near = (dx <= e) && (dy <= e);

    // cube: doubled coordinates
    assign cx2 = x0e <<< 1;
    assign cy2 = y0e <<< 1;
    assign lx2 = lxe <<< 1;
    assign hx2 = hxe <<< 1;
    assign ly2 = lye <<< 1;
    assign hy2 = hye <<< 1;
    assign cube_sel = i_contain
        ? (cx2 - e >= lx2 && cx2 + e <= hx2 && cy2 - e >= ly2 && cy2 + e <= hy2)
        : !(cx2 + e < lx2 || cx2 - e > hx2 || cy2 + e < ly2 || cy2 - e > hy2);

    always_comb begin
        o_geom.sel_simple = 1'b0;
        o_geom.circ_cross = 1'b0;
        o_geom.dx         = dx[EXT_BITS-1:0];
        o_geom.dy         = dy[EXT_BITS-1:0];
        case (i_cmd)
            CMD_LINE:   o_geom.sel_simple = !kill && line_sel;
            CMD_RECT:   o_geom.sel_simple = !kill && rect_sel;
            CMD_CIRCLE: begin
                o_geom.sel_simple = !kill && i_contain && circ_in;
                o_geom.circ_cross = !kill && !i_contain && near;
            end
            CMD_CUBE:   o_geom.sel_simple = !kill && cube_sel;
            default:    o_geom.sel_simple = 1'b0;
        endcase
    end

endmodule

// ===== rtl/window_box_select_test_unit.sv =====
`timescale 1ns / 1ps
// Top level of the window box select test: config registers and item pipeline.
// Depends on wbst_pkg and wbst_geom.
//
// Usage:
//   The window (two corners, contain mode, window entity id) is written over the
//   config channel (i_cfg_valid/o_cfg_ready, index, data); the user must write it
//   only while no item is in flight; the block does not enforce this. o_cfg_ready
//   is always high and unknown indexes are ignored. Entities enter on the s_
//   stream channel, one per cycle while s_tready is high, each giving one result
//   item on the m_ channel: the entity id and a selected flag. Each item passes
//   the input register, comparison stage, squaring stage and result register.
//   Throughput: one item per cycle while m_tready is high, set by the four-stage
//   register pipeline; the circle distance squares take a stage of their own.
//   Stall: when m_tready is low the result register holds; earlier stages keep
//   filling empty slots, and s_tready drops only once every stage is occupied.
//   Reset (i_rst_n low, synchronous) empties the pipeline and clears the window
//   registers to zero: both corners at the origin, crossing mode, id zero.
module window_box_select_test_unit #(
    parameter int COORD_BITS = wbst_pkg::COORD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [wbst_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [wbst_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entity_id, x0, y0, x1, y1, extent, zero fill
    input  logic [((wbst_pkg::ID_BITS + 4 * COORD_BITS + wbst_pkg::EXT_BITS + 7) / 8) * 8 - 1:0]
                                               s_tdata,
    // cmd, is_gizmo
    input  logic [wbst_pkg::IN_USER_BITS-1:0]  s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // result_id, selected, zero fill
    output logic [wbst_pkg::OUT_DATA_BITS-1:0] m_tdata
);
    import wbst_pkg::*;

    localparam int P_ID  = 0;
    localparam int P_X0  = P_ID + ID_BITS;
    localparam int P_Y0  = P_X0 + COORD_BITS;
    localparam int P_X1  = P_Y0 + COORD_BITS;
    localparam int P_Y1  = P_X1 + COORD_BITS;
    localparam int P_EXT = P_Y1 + COORD_BITS;

    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [COORD_BITS-1:0] r_lx, r_hx, r_ly, r_hy;
    logic                         r_contain;
    logic [ID_BITS-1:0]           r_win_id;

    logic                         r_v1, r_v2, r_v3, r_vo;
    logic [CMD_BITS-1:0]          r_s1_cmd;
    logic                         r_s1_gizmo;
    logic [ID_BITS-1:0]           r_s1_id, r_s2_id, r_s3_id, r_o_id;
    logic signed [COORD_BITS-1:0] r_s1_x0, r_s1_y0, r_s1_x1, r_s1_y1;
    logic [EXT_BITS-1:0]          r_s1_ext, r_s2_ext;
    t_geom                        r_s2_geom;
    logic                         r_s3_simple, r_s3_circ, r_o_sel;
    logic [PROD_BITS-1:0]         r_s3_dxx, r_s3_dyy, r_s3_ee;

    t_geom                        geom;
    logic                         rdy1, rdy2, rdy3, rdyo;
    logic                         n_sel;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax      <= '0;
            r_ay      <= '0;
            r_bx      <= '0;
            r_by      <= '0;
            r_contain <= 1'b0;
            r_win_id  <= '0;
            r_lx      <= '0;
            r_hx      <= '0;
            r_ly      <= '0;
            r_hy      <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_CORNER_A_X: r_ax      <= i_cfg_data[COORD_BITS-1:0];
                    REG_CORNER_A_Y: r_ay      <= i_cfg_data[COORD_BITS-1:0];
                    REG_CORNER_B_X: r_bx      <= i_cfg_data[COORD_BITS-1:0];
                    REG_CORNER_B_Y: r_by      <= i_cfg_data[COORD_BITS-1:0];
                    REG_CONTAIN:    r_contain <= i_cfg_data[0];
                    REG_WIN_ID:     r_win_id  <= i_cfg_data[ID_BITS-1:0];
                    default:        ;
                endcase
            end
            r_lx <= (r_ax < r_bx) ? r_ax : r_bx;
            r_hx <= (r_ax < r_bx) ? r_bx : r_ax;
            r_ly <= (r_ay < r_by) ? r_ay : r_by;
            r_hy <= (r_ay < r_by) ? r_by : r_ay;
        end
    end

    assign rdyo     = !r_vo || m_tready;
    assign rdy3     = !r_v3 || rdyo;
    assign rdy2     = !r_v2 || rdy3;
    assign rdy1     = !r_v1 || rdy2;
    assign s_tready = rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_tvalid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdyo) r_vo <= r_v3;
        end
    end

    wbst_geom #(
        .COORD_BITS(COORD_BITS)
    ) u_geom (
        .i_cmd     (r_s1_cmd),
        .i_id      (r_s1_id),
        .i_gizmo   (r_s1_gizmo),
        .i_x0      (r_s1_x0),
        .i_y0      (r_s1_y0),
        .i_x1      (r_s1_x1),
        .i_y1      (r_s1_y1),
        .i_ext     (r_s1_ext),
        .i_lx      (r_lx),
        .i_hx      (r_hx),
        .i_ly      (r_ly),
        .i_hy      (r_hy),
        .i_contain (r_contain),
        .i_win_id  (r_win_id),
        .o_geom    (geom)
    );

    assign n_sel = r_s3_simple
                || (r_s3_circ && ({1'b0, r_s3_dxx} + {1'b0, r_s3_dyy} <= {1'b0, r_s3_ee}));

    always_ff @(posedge i_clk) begin
        if (s_tvalid && rdy1) begin
            r_s1_cmd   <= s_tuser[CMD_BITS-1:0];
            r_s1_gizmo <= s_tuser[CMD_BITS];
            r_s1_id    <= s_tdata[P_ID +: ID_BITS];
            r_s1_x0    <= s_tdata[P_X0 +: COORD_BITS];
            r_s1_y0    <= s_tdata[P_Y0 +: COORD_BITS];
            r_s1_x1    <= s_tdata[P_X1 +: COORD_BITS];
            r_s1_y1    <= s_tdata[P_Y1 +: COORD_BITS];
            r_s1_ext   <= s_tdata[P_EXT +: EXT_BITS];
        end
        if (r_v1 && rdy2) begin
            r_s2_id   <= r_s1_id;
            r_s2_ext  <= r_s1_ext;
            r_s2_geom <= geom;
        end
        if (r_v2 && rdy3) begin
            r_s3_id     <= r_s2_id;
            r_s3_simple <= r_s2_geom.sel_simple;
            r_s3_circ   <= r_s2_geom.circ_cross;
            r_s3_dxx    <= r_s2_geom.dx * r_s2_geom.dx;
            r_s3_dyy    <= r_s2_geom.dy * r_s2_geom.dy;
            r_s3_ee     <= r_s2_ext * r_s2_ext;
        end
        if (r_v3 && rdyo) begin
            r_o_id  <= r_s3_id;
            r_o_sel <= n_sel;
        end
    end

    assign m_tvalid = r_vo;
    assign m_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}}, r_o_sel, r_o_id};

endmodule
